/* rtl/sab_pkg.sv */
// Shared types, codes and pixel helpers for the span alpha blender.
package sab_pkg;

  localparam logic [1:0] MODE_OPAQUE = 2'd0;
  localparam logic [1:0] MODE_ALPHA  = 2'd1;
  localparam logic [1:0] MODE_SOURCE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] REG_FILL_MODE    = 2'd0;
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd1;
  localparam logic [1:0] REG_FILL_COLOR   = 2'd2;
  localparam logic [1:0] REG_AA_THRESHOLD = 2'd3;

  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_RGB555 = 1'b1;

  localparam logic [7:0]  CHAN_MAX        = 8'hFF;
  localparam logic [31:0] FILL_COLOR_INIT = 32'hFF00_0000;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_DIRECT,
    KIND_BLEND
  } res_kind_t;

  typedef struct packed {
    logic [1:0]  fill_mode;
    logic        pixel_format;
    logic [31:0] fill_color;
    logic [7:0]  aa_threshold;
  } cfg_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [15:0] dest_pixel;
    logic [7:0]  alpha;
    logic [7:0]  sr;
    logic [7:0]  sg;
    logic [7:0]  sb;
  } stage1_t;

  typedef struct packed {
    res_kind_t    kind;
    logic [15:0]  dest_pixel;
    logic [7:0]   sr;
    logic [7:0]   sg;
    logic [7:0]   sb;
    logic [7:0]   dr;
    logic [7:0]   dg;
    logic [7:0]   db;
    logic [17:0]  pr;
    logic [17:0]  pg;
    logic [17:0]  pb;
  } stage2_t;

  function automatic logic [15:0] pack_pixel(input logic fmt, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
    if (fmt == FMT_RGB555) begin
      return {1'b0, r[7:3], g[7:3], b[7:3]};
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [23:0] unpack_pixel(input logic fmt, input logic [15:0] p);
    if (fmt == FMT_RGB555) begin
      return {p[14:10], 3'b000, p[9:5], 3'b000, p[4:0], 3'b000};
    end
    return {p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
  endfunction

endpackage

/* rtl/sab_front.sv */
// Stage 1: skip/direct/blend decision and effective alpha.
module sab_front (
  input  logic            clk,
  input  logic            rst,
  input  sab_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [15:0]     dest_pixel,
  input  logic [7:0]      coverage,
  input  logic [31:0]     source_color,
  output logic            out_valid,
  input  logic            out_ready,
  output sab_pkg::stage1_t out_data
);
  import sab_pkg::*;

  stage1_t    data_next;
  logic [7:0] a_in;
  logic [31:0] color;
  logic [16:0] prod;
  logic [7:0] sa;

  assign in_ready = !out_valid || out_ready;
  assign sa = source_color[31:24];

  always_comb begin
    a_in  = CHAN_MAX;
    color = cfg.fill_color;
    data_next.kind = KIND_SKIP;
    case (cfg.fill_mode)
      MODE_OPAQUE: begin
        data_next.kind = (coverage == CHAN_MAX) ? KIND_DIRECT : KIND_BLEND;
      end
      MODE_ALPHA: begin
        a_in = cfg.fill_color[31:24];
        data_next.kind = KIND_BLEND;
      end
      MODE_SOURCE: begin
        a_in  = sa;
        color = source_color;
        if (sa == 8'd0) begin
          data_next.kind = KIND_SKIP;
        end else if (sa == CHAN_MAX && coverage == CHAN_MAX) begin
          data_next.kind = KIND_DIRECT;
        end else begin
          data_next.kind = KIND_BLEND;
        end
      end
      default: data_next.kind = KIND_SKIP;
    endcase
    if (coverage < cfg.aa_threshold) begin
      data_next.kind = KIND_SKIP;
    end
    prod = 17'({1'b0, a_in} + 9'd1) * 17'(coverage);
    data_next.alpha      = prod[15:8];
    data_next.dest_pixel = dest_pixel;
    data_next.sr         = color[23:16];
    data_next.sg         = color[15:8];
    data_next.sb         = color[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/sab_mul.sv */
// Stage 2: destination unpack and per-channel alpha products.
module sab_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_format,
  input  logic             in_valid,
  output logic             in_ready,
  input  sab_pkg::stage1_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sab_pkg::stage2_t out_data
);
  import sab_pkg::*;

  stage2_t            data_next;
  logic [23:0]        dst;
  logic signed [9:0]  a1;
  logic signed [9:0]  diff_r;
  logic signed [9:0]  diff_g;
  logic signed [9:0]  diff_b;
  logic signed [19:0] mr;
  logic signed [19:0] mg;
  logic signed [19:0] mb;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dst    = unpack_pixel(pixel_format, in_data.dest_pixel);
    a1     = $signed({2'b00, in_data.alpha} + 10'd1);
    diff_r = $signed({2'b00, in_data.sr}) - $signed({2'b00, dst[23:16]});
    diff_g = $signed({2'b00, in_data.sg}) - $signed({2'b00, dst[15:8]});
    diff_b = $signed({2'b00, in_data.sb}) - $signed({2'b00, dst[7:0]});
    mr     = a1 * diff_r;
    mg     = a1 * diff_g;
    mb     = a1 * diff_b;
    data_next.kind       = in_data.kind;
    data_next.dest_pixel = in_data.dest_pixel;
    data_next.sr         = in_data.sr;
    data_next.sg         = in_data.sg;
    data_next.sb         = in_data.sb;
    data_next.dr         = dst[23:16];
    data_next.dg         = dst[15:8];
    data_next.db         = dst[7:0];
    data_next.pr         = mr[17:0];
    data_next.pg         = mg[17:0];
    data_next.pb         = mb[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/sab_pack.sv */
// Stage 3: channel sums, result select and repack into the output register.
module sab_pack (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_format,
  input  logic             in_valid,
  output logic             in_ready,
  input  sab_pkg::stage2_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      new_pixel,
  output logic             written
);
  import sab_pkg::*;

  logic [7:0]  br;
  logic [7:0]  bg;
  logic [7:0]  bb;
  logic [15:0] pixel_next;
  logic        written_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    br = 8'(in_data.dr + in_data.pr[15:8]);
    bg = 8'(in_data.dg + in_data.pg[15:8]);
    bb = 8'(in_data.db + in_data.pb[15:8]);
    case (in_data.kind)
      KIND_DIRECT: begin
        pixel_next   = pack_pixel(pixel_format, in_data.sr, in_data.sg, in_data.sb);
        written_next = 1'b1;
      end
      KIND_BLEND: begin
        pixel_next   = pack_pixel(pixel_format, br, bg, bb);
        written_next = 1'b1;
      end
      default: begin
        pixel_next   = in_data.dest_pixel;
        written_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      new_pixel <= pixel_next;
      written   <= written_next;
    end
  end

endmodule

/* rtl/span_alpha_blend_rgb565_555.sv */
// Top level of the span alpha blender: config registers and three-stage pipeline.
//
//  channel  handshake             payload
//  in       in_valid / in_ready   dest_pixel, coverage, source_color
//  out      out_valid / out_ready new_pixel, written
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while out_ready stays high; the register stages are the
// decision/alpha multiply, channel multiply and sum/pack stages.
// Synchronous reset clears all stage valid bits and loads register defaults.
// Each stage holds on a downstream stall and still fills when it is empty.
module span_alpha_blend_rgb565_555 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] dest_pixel,
  input  logic [7:0]  coverage,
  input  logic [31:0] source_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] new_pixel,
  output logic        written,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sab_pkg::*;

  cfg_t    cfg;
  logic    s1_valid;
  logic    s1_ready;
  stage1_t s1_data;
  logic    s2_valid;
  logic    s2_ready;
  stage2_t s2_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_mode    <= MODE_OPAQUE;
      cfg.pixel_format <= FMT_RGB565;
      cfg.fill_color   <= FILL_COLOR_INIT;
      cfg.aa_threshold <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILL_MODE:    cfg.fill_mode    <= cfg_data[1:0];
        REG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[0];
        REG_FILL_COLOR:   cfg.fill_color   <= cfg_data;
        REG_AA_THRESHOLD: cfg.aa_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  sab_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .dest_pixel   (dest_pixel),
    .coverage     (coverage),
    .source_color (source_color),
    .out_valid    (s1_valid),
    .out_ready    (s1_ready),
    .out_data     (s1_data)
  );

  sab_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .pixel_format (cfg.pixel_format),
    .in_valid     (s1_valid),
    .in_ready     (s1_ready),
    .in_data      (s1_data),
    .out_valid    (s2_valid),
    .out_ready    (s2_ready),
    .out_data     (s2_data)
  );

  sab_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .pixel_format (cfg.pixel_format),
    .in_valid     (s2_valid),
    .in_ready     (s2_ready),
    .in_data      (s2_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .new_pixel    (new_pixel),
    .written      (written)
  );

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty first stage");

  a_555_top_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && written && cfg.pixel_format == FMT_RGB555 |-> !new_pixel[15])
    else $error("written RGB555 pixel has top bit set");

  a_unused_mode_skips: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.fill_mode == MODE_UNUSED |-> !written)
    else $error("pixel written in unused fill mode");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s1_valid && !s2_valid)
    else $error("pipeline holds an item right after reset");

endmodule

/* tb/span_alpha_blend_rgb565_555_tb.sv */
// Self-checking testbench for the span alpha blender: queued pixel driver, blend predictor, monitor.
`timescale 1ns / 1ps

module span_alpha_blend_rgb565_555_tb;
  import sab_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 120;
  localparam int MAX_PRINTED = 100;

  typedef struct {
    logic [15:0] dest;
    logic [7:0]  cov;
    logic [31:0] src;
  } span_pixel_t;

  typedef struct {
    logic [15:0] pixel;
    logic        wr;
  } blended_pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] dest_pixel = '0;
  logic [7:0]  coverage = '0;
  logic [31:0] source_color = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] new_pixel;
  logic        written;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  span_pixel_t    pixel_queue[$];
  blended_pixel_t expected_pixels[$];
  span_pixel_t    next_px;
  span_pixel_t    seen_px;
  blended_pixel_t want;

  int mismatch_count = 0;
  int pixels_queued = 0;
  int results_seen = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 20;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  logic [1:0]  blend_mode;
  logic        dst_fmt;
  logic [31:0] fill_argb;
  logic [7:0]  cov_threshold;

  span_alpha_blend_rgb565_555 uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .dest_pixel   (dest_pixel),
    .coverage     (coverage),
    .source_color (source_color),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .new_pixel    (new_pixel),
    .written      (written),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic logic [7:0] mix_channel(input logic [7:0] a, input logic [7:0] s,
                                             input logic [7:0] d);
    int diff_scaled;
    diff_scaled = (int'(a) + 1) * (int'(s) - int'(d));
    return 8'(int'(d) + (diff_scaled >>> 8));
  endfunction

  function automatic logic [7:0] coverage_alpha(input logic [7:0] a, input logic [7:0] c);
    return 8'(((int'(a) + 1) * int'(c)) >> 8);
  endfunction

  function automatic logic [15:0] rgb16(input logic fmt, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
    logic [15:0] packed_px;
    if (fmt == FMT_RGB555) begin
      packed_px = (16'(r & 8'hF8) << 7) | (16'(g & 8'hF8) << 2) | (16'(b & 8'hF8) >> 3);
    end else begin
      packed_px = (16'(r & 8'hF8) << 8) | (16'(g & 8'hFC) << 3) | (16'(b & 8'hF8) >> 3);
    end
    return packed_px;
  endfunction

  function automatic logic [15:0] solid_argb(input logic fmt, input logic [31:0] argb);
    return rgb16(fmt, argb[23:16], argb[15:8], argb[7:0]);
  endfunction

  function automatic logic [15:0] blend_over(input logic fmt, input logic [31:0] argb,
                                             input logic [7:0] a, input logic [15:0] dst);
    logic [7:0] dr, dg, db;
    if (fmt == FMT_RGB555) begin
      dr = {dst[14:10], 3'b000};
      dg = {dst[9:5], 3'b000};
    end else begin
      dr = {dst[15:11], 3'b000};
      dg = {dst[10:5], 2'b00};
    end
    db = {dst[4:0], 3'b000};
    return rgb16(fmt, mix_channel(a, argb[23:16], dr), mix_channel(a, argb[15:8], dg),
                 mix_channel(a, argb[7:0], db));
  endfunction

  function automatic blended_pixel_t predict_blend(input span_pixel_t px);
    blended_pixel_t res;
    logic [7:0] src_alpha;
    res.pixel = px.dest;
    res.wr = 1'b0;
    src_alpha = px.src[31:24];
    if (px.cov >= cov_threshold) begin
      case (blend_mode)
        MODE_OPAQUE: begin
          res.wr = 1'b1;
          if (px.cov == CHAN_MAX) begin
            res.pixel = solid_argb(dst_fmt, fill_argb);
          end else begin
            res.pixel = blend_over(dst_fmt, fill_argb, coverage_alpha(CHAN_MAX, px.cov), px.dest);
          end
        end
        MODE_ALPHA: begin
          res.wr = 1'b1;
          res.pixel = blend_over(dst_fmt, fill_argb, coverage_alpha(fill_argb[31:24], px.cov),
                                 px.dest);
        end
        MODE_SOURCE: begin
          if (src_alpha != 8'h00) begin
            res.wr = 1'b1;
            if (src_alpha == CHAN_MAX && px.cov == CHAN_MAX) begin
              res.pixel = solid_argb(dst_fmt, px.src);
            end else begin
              res.pixel = blend_over(dst_fmt, px.src, coverage_alpha(src_alpha, px.cov), px.dest);
            end
          end
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic queue_pixel(input logic [15:0] dest, input logic [7:0] cov,
                             input logic [31:0] src);
    span_pixel_t px;
    px.dest = dest;
    px.cov = cov;
    px.src = src;
    pixel_queue.push_back(px);
    pixels_queued++;
  endtask

  task automatic queue_random_pixel(input logic [7:0] thr);
    logic [7:0] cov;
    logic [7:0] alpha;
    case ($urandom_range(0, 7))
      0: cov = 8'h00;
      1: cov = CHAN_MAX;
      2: cov = thr;
      3: cov = thr - 8'd1;
      default: cov = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: alpha = 8'h00;
      1: alpha = CHAN_MAX;
      default: alpha = 8'($urandom);
    endcase
    queue_pixel(16'($urandom), cov, {alpha, 24'($urandom)});
  endtask

  task automatic drain_results();
    while (results_seen != pixels_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic fmt, input logic [31:0] color,
                            input logic [7:0] thr);
    write_reg(REG_FILL_MODE, (32'($urandom) & ~32'h3) | 32'(mode));
    write_reg(REG_PIXEL_FORMAT, (32'($urandom) & ~32'h1) | 32'(fmt));
    write_reg(REG_FILL_COLOR, color);
    write_reg(REG_AA_THRESHOLD, (32'($urandom) & ~32'hFF) | 32'(thr));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        next_px = pixel_queue.pop_front();
        in_valid <= 1'b1;
        dest_pixel <= next_px.dest;
        coverage <= next_px.cov;
        source_color <= next_px.src;
        if ($urandom_range(0, 99) < send_idle_pct) begin
          send_gap <= $urandom_range(1, 17);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      recv_stall <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_OPAQUE;
      dst_fmt <= FMT_RGB565;
      fill_argb <= FILL_COLOR_INIT;
      cov_threshold <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILL_MODE:    blend_mode <= cfg_data[1:0];
          REG_PIXEL_FORMAT: dst_fmt <= cfg_data[0];
          REG_FILL_COLOR:   fill_argb <= cfg_data;
          REG_AA_THRESHOLD: cov_threshold <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        seen_px.dest = dest_pixel;
        seen_px.cov = coverage;
        seen_px.src = source_color;
        expected_pixels.push_back(predict_blend(seen_px));
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result with no pending item: new_pixel %h written %b",
                                    new_pixel, written));
        end else begin
          want = expected_pixels.pop_front();
          if (new_pixel !== want.pixel) begin
            report_mismatch($sformatf("new_pixel got %h want %h", new_pixel, want.pixel));
          end
          if (written !== want.wr) begin
            report_mismatch($sformatf("written got %b want %b", written, want.wr));
          end
        end
      end
    end
  end

  initial begin
    logic [1:0]  mode;
    logic        fmt;
    logic [31:0] color;
    logic [7:0]  thr;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_pixel(16'h0000, 8'hFF, 32'h0000_0000);
    queue_pixel(16'hFFFF, 8'hFE, 32'hFFFF_FFFF);
    queue_pixel(16'hFFFF, 8'h00, 32'h0000_0000);
    queue_pixel(16'hA5A5, 8'h80, 32'h0000_0000);
    drain_results();

    set_config(MODE_ALPHA, FMT_RGB555, 32'h80FF_00FF, 8'h00);
    queue_pixel(16'hFFFF, 8'hFF, 32'h0000_0000);
    queue_pixel(16'h8000, 8'h00, 32'h0000_0000);
    queue_pixel(16'h7FFF, 8'h64, 32'h0000_0000);
    drain_results();

    set_config(MODE_ALPHA, FMT_RGB565, 32'h00FF_FFFF, 8'h00);
    queue_pixel(16'hFFFF, 8'hFF, 32'h0000_0000);
    queue_pixel(16'h0841, 8'h10, 32'h0000_0000);
    drain_results();

    set_config(MODE_SOURCE, FMT_RGB565, 32'h0000_0000, 8'h00);
    queue_pixel(16'h1234, 8'hFF, 32'h00FF_FFFF);
    queue_pixel(16'h0000, 8'hFF, 32'hFF12_3456);
    queue_pixel(16'hFFFF, 8'hC8, 32'hFF00_FF00);
    queue_pixel(16'hFFFF, 8'h01, 32'h01FF_FFFF);
    queue_pixel(16'h5555, 8'hFF, 32'h80FF_8040);
    drain_results();

    set_config(MODE_SOURCE, FMT_RGB555, 32'h0000_0000, 8'd200);
    queue_pixel(16'hFFFF, 8'd199, 32'hFFFF_FFFF);
    queue_pixel(16'h8000, 8'd200, 32'hFF00_0000);
    queue_pixel(16'h1234, 8'd0, 32'h8080_8080);
    drain_results();

    set_config(MODE_UNUSED, FMT_RGB565, 32'hFFFF_FFFF, 8'h00);
    queue_pixel(16'hBEEF, 8'hFF, 32'hFFFF_FFFF);
    queue_pixel(16'h0000, 8'h00, 32'h0000_0000);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = (phase == 5) ? MODE_UNUSED : 2'(phase % 3);
      fmt = phase[0];
      if (phase == 1) begin
        color = 32'h0000_0000;
      end else if (phase == 4) begin
        color = 32'hFFFF_FFFF;
      end else begin
        color = $urandom;
      end
      if (phase == 2 || phase == 8) begin
        thr = 8'hFF;
      end else if (phase % 4 == 0) begin
        thr = 8'h00;
      end else begin
        thr = 8'($urandom_range(0, 255));
      end
      if (phase == RANDOM_PHASES - 1 || phase % 3 == 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = (phase % 3 == 1) ? 10 : 30;
        recv_idle_pct = (phase % 3 == 1) ? 30 : 10;
      end
      set_config(mode, fmt, color, thr);
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        queue_random_pixel(thr);
      end
      if (phase == 7) begin
        hold_requests <= hold_requests + 1;
      end
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("span_alpha_blend_rgb565_555 regression: pass");
    end else begin
      $display("span_alpha_blend_rgb565_555 regression: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("span_alpha_blend_rgb565_555 regression: fail");
    $finish;
  end

endmodule
